// File: sv/cmaf_pkg.sv
`default_nettype none

package cmaf_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int COUNT_OUT_W = 6;

  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_PASS    = 3'd1;
  localparam logic [2:0] OP_DISCARD = 3'd2;
  localparam logic [2:0] OP_ADD     = 3'd3;
  localparam logic [2:0] OP_CHECK   = 3'd4;

  localparam logic [1:0] MODE_DISCARD = 2'd0;
  localparam logic [1:0] MODE_PASS    = 2'd1;
  localparam logic [1:0] MODE_LIST    = 2'd2;

  localparam logic [7:0]  ADDR_ANY = 8'hFF;
  localparam logic [23:0] PGN_ANY  = 24'h000000;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [23:0] msg_pgn;
    logic [7:0]  msg_addr;
    logic        use_pgn;
    logic        use_addr;
  } cmd_t;

  typedef struct packed {
    logic                   accepted;
    logic                   add_refused;
    logic [COUNT_OUT_W-1:0] entry_count;
  } res_t;

  typedef struct packed {
    logic [7:0]  addr;
    logic [23:0] pgn;
  } entry_t;

endpackage

`default_nettype wire

// File: sv/cmaf_table.sv
`default_nettype none

module cmaf_table (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [cmaf_pkg::IDX_W-1:0] wr_idx,
  input  wire cmaf_pkg::entry_t          wr_entry,
  input  wire logic [cmaf_pkg::IDX_W-1:0] rd_idx,
  input  wire cmaf_pkg::entry_t          key,
  output logic                           hit
);

  cmaf_pkg::entry_t mem [cmaf_pkg::MAX_ENTRIES];
  cmaf_pkg::entry_t rd_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    rd_q <= mem[rd_idx];
  end

  // wildcard fields in the stored entry match anything
  always_comb begin
    hit = ((rd_q.addr == key.addr) || (rd_q.addr == cmaf_pkg::ADDR_ANY)) &&
          ((rd_q.pgn == key.pgn) || (rd_q.pgn == cmaf_pkg::PGN_ANY));
  end

endmodule

`default_nettype wire

// File: sv/can_message_acceptance_filter_top.sv
// J1939 acceptance filter: one command word in, one result word out. Clear, mode and add
// commands, and checks in pass-all or discard-all mode or against an empty table, answer
// in the cycle after acceptance. A check in list mode scans the stored entries one per
// cycle through the table memory's single read port and stops at the first match. Each
// entry is read into the table's read register and compared with the key, and the outcome
// goes via hit_q into the result register. No new command is taken while a scan runs or
// while the result register is full and stalled. Entries past the fill count are never
// read, so clearing the table only zeroes the count and needs no sweep of the memory.
`default_nettype none

module can_message_acceptance_filter_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire cmaf_pkg::cmd_t cmd,
  output logic                res_valid,
  input  wire logic           res_stall,
  output cmaf_pkg::res_t      res
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  localparam int CW = cmaf_pkg::CNT_W;
  localparam int IW = cmaf_pkg::IDX_W;

  logic [1:0]             state;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [1:0]             mode;
  logic [1:0]             mode_next;
  cmaf_pkg::entry_t       key;
  logic [IW-1:0]          scan_idx;
  logic                   issued_all;
  logic                   data_valid;
  logic                   data_last;
  logic                   hit_q;
  logic                   hit;

  logic                   cmd_acc;
  logic                   res_free;
  logic                   is_list;
  logic                   add_full;
  logic                   scan_start;
  logic                   wr_en;
  cmaf_pkg::entry_t       wr_entry;
  cmaf_pkg::res_t         imm_res;
  logic                   issue;
  logic                   last_issue;
  logic                   finish;
  logic                   res_load;

  cmaf_table u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_idx   (count[IW-1:0]),
    .wr_entry (wr_entry),
    .rd_idx   (scan_idx),
    .key      (key),
    .hit      (hit)
  );

  always_comb begin
    res_free  = !res_valid || !res_stall;
    cmd_stall = (state != ST_IDLE) || !res_free;
    cmd_acc   = cmd_valid && !cmd_stall;
    // mode code 3 is unreachable but would behave as list
    is_list   = (mode != cmaf_pkg::MODE_PASS) && (mode != cmaf_pkg::MODE_DISCARD);
    add_full  = count >= CW'(cmaf_pkg::MAX_ENTRIES);

    // a skipped field is written as a wildcard, which matches anything
    wr_entry.addr = cmd.use_addr ? cmd.msg_addr : cmaf_pkg::ADDR_ANY;
    wr_entry.pgn  = cmd.use_pgn ? cmd.msg_pgn : cmaf_pkg::PGN_ANY;
    wr_en         = cmd_acc && (cmd.opcode == cmaf_pkg::OP_ADD) && !add_full;

    count_next = count;
    mode_next  = mode;
    unique case (cmd.opcode)
      cmaf_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      cmaf_pkg::OP_PASS: begin
        count_next = '0;
        mode_next  = cmaf_pkg::MODE_PASS;
      end
      cmaf_pkg::OP_DISCARD: begin
        count_next = '0;
        mode_next  = cmaf_pkg::MODE_DISCARD;
      end
      cmaf_pkg::OP_ADD: begin
        mode_next = cmaf_pkg::MODE_LIST;
        if (!add_full) begin
          count_next = count + CW'(1);
        end
      end
      default: begin
      end
    endcase

    scan_start = cmd_acc && (cmd.opcode == cmaf_pkg::OP_CHECK) && is_list &&
                 (count != '0);

    imm_res.accepted    = (cmd.opcode == cmaf_pkg::OP_CHECK) &&
                          (mode == cmaf_pkg::MODE_PASS);
    imm_res.add_refused = (cmd.opcode == cmaf_pkg::OP_ADD) && add_full;
    imm_res.entry_count = cmaf_pkg::COUNT_OUT_W'(count_next);

    issue      = (state == ST_SCAN) && !issued_all;
    last_issue = (CW'(scan_idx) + CW'(1)) == count;
    finish     = (state == ST_SCAN) && data_valid && (hit || data_last);

    res_load   = ((state == ST_IDLE) && cmd_acc && !scan_start) ||
                 ((state == ST_RESULT) && res_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      mode       <= cmaf_pkg::MODE_DISCARD;
      res_valid  <= 1'b0;
      data_valid <= 1'b0;
      issued_all <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_acc) begin
            count <= count_next;
            mode  <= mode_next;
            if (scan_start) begin
              state      <= ST_SCAN;
              scan_idx   <= '0;
              issued_all <= 1'b0;
              data_valid <= 1'b0;
              key.addr   <= cmd.msg_addr;
              key.pgn    <= cmd.msg_pgn;
            end else begin
              res <= imm_res;
            end
          end
        end
        ST_SCAN: begin
          // read issued this cycle is compared in the next one
          data_valid <= issue && !finish;
          data_last  <= last_issue;
          if (issue) begin
            scan_idx <= scan_idx + IW'(1);
            if (last_issue) begin
              issued_all <= 1'b1;
            end
          end
          if (finish) begin
            state <= ST_RESULT;
            hit_q <= hit;
          end
        end
        ST_RESULT: begin
          if (res_free) begin
            res.accepted    <= hit_q;
            res.add_refused <= 1'b0;
            res.entry_count <= cmaf_pkg::COUNT_OUT_W'(count);
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(cmaf_pkg::MAX_ENTRIES))
    else $error("entry count above table size");

  a_data_in_scan: assert property (@(posedge clk) disable iff (rst)
    data_valid |-> (state == ST_SCAN))
    else $error("table read data pending outside a scan");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && (cmd.opcode == cmaf_pkg::OP_ADD) && (count == CW'(cmaf_pkg::MAX_ENTRIES)))
      |=> (res_valid && res.add_refused))
    else $error("add to full table not refused");

  a_no_table_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !wr_en)
    else $error("table written during a scan");

endmodule

`default_nettype wire
